// ===== rtl/ouart_pkg.sv =====
// ----------------------------------------------------------------------------
// ouart_pkg
// Types and constants shared by the oversampled UART transceiver modules.
// ----------------------------------------------------------------------------
package ouart_pkg;

  // Configuration register indexes
  localparam logic [0:0] CFG_TICKS_PER_BIT      = 1'd0;
  localparam logic [0:0] CFG_MAJORITY_THRESHOLD = 1'd1;

  localparam logic [7:0] TICKS_PER_BIT_RESET      = 8'd10;
  localparam logic [7:0] MAJORITY_THRESHOLD_RESET = 8'd5;

  // Frame positions, counted in bit windows
  localparam logic [3:0] BIT_START     = 4'd0;
  localparam logic [3:0] BIT_LAST_DATA = 4'd8;
  localparam logic [3:0] BIT_STOP      = 4'd9;

  localparam logic [7:0] COUNT_MAX = 8'hff;

  typedef struct packed {
    logic       rx_level;
    logic       send_request;
    logic [7:0] send_byte;
  } ouart_tick_t;

  typedef struct packed {
    logic       tx_level;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       tx_ready;
  } ouart_result_t;

endpackage

// ===== rtl/ouart_core.sv =====
// ----------------------------------------------------------------------------
// ouart_core
// Frame state of the receiver and transmitter, advanced once per tick word.
// ----------------------------------------------------------------------------
module ouart_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  ouart_pkg::ouart_tick_t  tick,
  input  logic [7:0]              ticks_per_bit,
  input  logic [7:0]              majority_threshold,
  output ouart_pkg::ouart_result_t res
);
  import ouart_pkg::*;

  logic       rx_active, rx_active_next;
  logic [7:0] rx_tick_count, rx_tick_count_next;
  logic [7:0] rx_high_count, rx_high_count_next;
  logic [3:0] rx_bit_index, rx_bit_index_next;
  logic [7:0] rx_shift, rx_shift_next;
  logic       tx_busy, tx_busy_next;
  logic [7:0] tx_tick_count, tx_tick_count_next;
  logic [3:0] tx_bit_index, tx_bit_index_next;
  logic [7:0] tx_data, tx_data_next;
  logic       tx_line, tx_line_next;

  logic       rx_start;
  logic [7:0] rx_tick_inc;
  logic [7:0] rx_high_base;
  logic [7:0] rx_high_inc;
  logic [3:0] rx_bit_base;
  logic [7:0] rx_shift_base;
  logic [3:0] rx_pos;
  logic       rx_one;
  logic       rx_valid;
  logic [7:0] tx_tick_inc;
  logic [3:0] tx_bit_inc;
  logic [3:0] tx_pos;

  // Transmitter
  always_comb begin
    tx_busy_next       = tx_busy;
    tx_tick_count_next = tx_tick_count;
    tx_bit_index_next  = tx_bit_index;
    tx_data_next       = tx_data;
    tx_line_next       = tx_line;
    tx_tick_inc        = tx_tick_count + 8'd1;
    tx_bit_inc         = tx_bit_index + 4'd1;
    tx_pos             = tx_bit_inc - 4'd1;
    if (tx_busy) begin
      tx_tick_count_next = tx_tick_inc;
      if (tx_tick_inc >= ticks_per_bit) begin
        tx_tick_count_next = 8'd0;
        tx_bit_index_next  = tx_bit_inc;
        if (tx_bit_inc <= BIT_LAST_DATA) begin
          tx_line_next = tx_data[tx_pos[2:0]];
        end else if (tx_bit_inc == BIT_STOP) begin
          tx_line_next = 1'b1;
        end else begin
          // stop bit done: back to idle
          tx_busy_next      = 1'b0;
          tx_bit_index_next = BIT_START;
          tx_line_next      = 1'b1;
        end
      end
    end else if (tick.send_request) begin
      tx_busy_next       = 1'b1;
      tx_data_next       = tick.send_byte;
      tx_tick_count_next = 8'd0;
      tx_bit_index_next  = BIT_START;
      tx_line_next       = 1'b0;
    end
  end

  // Receiver
  always_comb begin
    rx_start      = !rx_active && !tick.rx_level;
    rx_high_base  = rx_start ? 8'd0 : rx_high_count;
    rx_bit_base   = rx_start ? BIT_START : rx_bit_index;
    rx_shift_base = rx_start ? 8'd0 : rx_shift;
    rx_tick_inc   = (rx_start ? 8'd0 : rx_tick_count) + 8'd1;
    rx_high_inc   = (tick.rx_level && rx_high_base != COUNT_MAX) ?
                    rx_high_base + 8'd1 : rx_high_base;
    rx_pos        = rx_bit_base - 4'd1;
    rx_one        = rx_high_inc > majority_threshold;

    rx_active_next     = rx_active;
    rx_tick_count_next = rx_tick_count;
    rx_high_count_next = rx_high_count;
    rx_bit_index_next  = rx_bit_index;
    rx_shift_next      = rx_shift;
    rx_valid           = 1'b0;

    if (rx_active || rx_start) begin
      rx_active_next     = 1'b1;
      rx_tick_count_next = rx_tick_inc;
      rx_high_count_next = rx_high_inc;
      rx_bit_index_next  = rx_bit_base;
      rx_shift_next      = rx_shift_base;
      if (rx_tick_inc >= ticks_per_bit) begin
        rx_tick_count_next = 8'd0;
        rx_high_count_next = 8'd0;
        if (rx_bit_base == BIT_START) begin
          // high start bit: abandon the frame
          if (rx_one) begin
            rx_active_next = 1'b0;
          end else begin
            rx_bit_index_next = rx_bit_base + 4'd1;
          end
        end else if (rx_bit_base <= BIT_LAST_DATA) begin
          if (rx_one) begin
            rx_shift_next[rx_pos[2:0]] = 1'b1;
          end
          rx_bit_index_next = rx_bit_base + 4'd1;
        end else begin
          rx_valid          = rx_one;
          rx_active_next    = 1'b0;
          rx_bit_index_next = BIT_START;
        end
      end
    end
  end

  always_comb begin
    res.tx_level = tx_line_next;
    res.rx_valid = rx_valid;
    res.rx_byte  = rx_valid ? rx_shift_base : 8'd0;
    res.tx_ready = !tx_busy_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_active     <= 1'b0;
      rx_tick_count <= 8'd0;
      rx_high_count <= 8'd0;
      rx_bit_index  <= BIT_START;
      rx_shift      <= 8'd0;
      tx_busy       <= 1'b0;
      tx_tick_count <= 8'd0;
      tx_bit_index  <= BIT_START;
      tx_data       <= 8'd0;
      tx_line       <= 1'b1;
    end else if (step) begin
      rx_active     <= rx_active_next;
      rx_tick_count <= rx_tick_count_next;
      rx_high_count <= rx_high_count_next;
      rx_bit_index  <= rx_bit_index_next;
      rx_shift      <= rx_shift_next;
      tx_busy       <= tx_busy_next;
      tx_tick_count <= tx_tick_count_next;
      tx_bit_index  <= tx_bit_index_next;
      tx_data       <= tx_data_next;
      tx_line       <= tx_line_next;
    end
  end

endmodule

// ===== rtl/oversampled_uart_transceiver.sv =====
// ----------------------------------------------------------------------------
// oversampled_uart_transceiver
// Tick-driven 8N1 UART with majority-vote receive over each bit window.
// ----------------------------------------------------------------------------
// Each word on the tick channel is one oversampling tick: the sampled
// receive line level plus an optional byte to send. Every accepted tick
// word gives exactly one result word: the transmit line level after that
// tick, a received-byte strobe with its byte, and transmitter readiness.
// A result is registered when its tick word is accepted. One tick word
// can be taken every cycle while tick_stall is low; the frame state updates
// in a single pass and the result register is the only stage.
// When the result consumer stalls, the pending result holds and one more
// tick word lands in a skid register; tick_stall then rises until the skid
// register drains, so no word is lost or repeated.
// Reset returns both receiver and transmitter to idle, the line to high,
// ticks_per_bit to 10 and majority_threshold to 5, and empties the output.
// Write the configuration registers only while no result is outstanding.
// ----------------------------------------------------------------------------
module oversampled_uart_transceiver (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     tick_valid,
  output logic                     tick_stall,
  input  ouart_pkg::ouart_tick_t   tick,
  output logic                     result_valid,
  input  logic                     result_stall,
  output ouart_pkg::ouart_result_t result,
  input  logic                     cfg_wr_en,
  input  logic [0:0]               cfg_index,
  input  logic [7:0]               cfg_data
);
  import ouart_pkg::*;

  logic          accept;
  logic          take;
  logic [7:0]    ticks_per_bit;
  logic [7:0]    majority_threshold;
  ouart_result_t core_res;
  logic          skid_valid;
  ouart_result_t skid;

  assign tick_stall = skid_valid;
  assign accept     = tick_valid && !skid_valid;
  assign take       = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_bit      <= TICKS_PER_BIT_RESET;
      majority_threshold <= MAJORITY_THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TICKS_PER_BIT:      ticks_per_bit      <= cfg_data;
        CFG_MAJORITY_THRESHOLD: majority_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  ouart_core u_core (
    .clk                (clk),
    .rst                (rst),
    .step               (accept),
    .tick               (tick),
    .ticks_per_bit      (ticks_per_bit),
    .majority_threshold (majority_threshold),
    .res                (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (result_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

  // payload: refill from skid first, park a new word if the output is held
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        result <= skid;
      end
    end else if (accept) begin
      if (result_valid && !take) begin
        skid <= core_res;
      end else begin
        result <= core_res;
      end
    end
  end

endmodule

// ===== rtl/ouart_checker.sv =====
// ----------------------------------------------------------------------------
// ouart_checker
// Port-level checks for the oversampled UART transceiver.
// ----------------------------------------------------------------------------
module ouart_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     tick_stall,
  input logic                     result_valid,
  input logic                     result_stall,
  input ouart_pkg::ouart_result_t result
);
  import ouart_pkg::*;

  // skid fills only while a result is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(tick_stall) |-> $past(result_valid && result_stall))
    else $error("tick_stall rose without a held result");

  a_idle_line_high: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.tx_ready) |-> result.tx_level)
    else $error("idle transmitter drives a low line");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.rx_valid) |-> (result.rx_byte == 8'd0))
    else $error("rx_byte nonzero without rx_valid");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind oversampled_uart_transceiver ouart_checker u_ouart_checker (
  .clk          (clk),
  .rst          (rst),
  .tick_stall   (tick_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
